[design/rprm_pkg.sv]
package rprm_pkg;

    localparam int TICK_W   = 11;
    localparam int PERIOD_W = 16;
    localparam int FAULT_W  = 4;
    localparam int MODE_W   = 2;
    localparam int ALARM_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [MODE_W-1:0] MODE_IDLE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_TEST  = 2'd2;

    localparam logic [ALARM_W-1:0] ALARM_NONE     = 2'd0;
    localparam logic [ALARM_W-1:0] ALARM_OVERRUN  = 2'd1;
    localparam logic [ALARM_W-1:0] ALARM_UNDERRUN = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED = 2'd3;

    localparam logic [TICK_W-1:0]   TICK_MAX     = 11'd2047;
    localparam logic [PERIOD_W:0]   LIMIT_MARGIN = 17'd50;
    localparam logic [PERIOD_W-1:0] SHORT_PERIOD = 16'd20;
    localparam logic [FAULT_W-1:0]  SHORT_LIMIT  = 4'd4;
    localparam logic [FAULT_W-1:0]  RANGE_LIMIT  = 4'd8;
    localparam logic [FAULT_W-1:0]  FAULT_MAX    = 4'd15;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [PERIOD_W-1:0] lower_limit;
        logic [PERIOD_W-1:0] upper_limit;
        logic [PERIOD_W-1:0] expected_period;
    } cfg_t;

    typedef struct packed {
        logic [ALARM_W-1:0]         alarm;
        logic                       edge_counted;
        logic [PERIOD_W-1:0]        cycle_period;
        logic [PERIOD_W-1:0]        measured_period;
        logic signed [PERIOD_W-1:0] period_delta;
    } result_t;

    // ticks * 50 as shifts and adds, clamped to 16 bits
    function automatic logic [PERIOD_W-1:0] to_period(input logic [TICK_W-1:0] t);
        logic [TICK_W+5:0] p;
        p = ({6'd0, t} << 5) + ({6'd0, t} << 4) + ({6'd0, t} << 1);
        to_period = (p > {1'b0, {PERIOD_W{1'b1}}}) ? {PERIOD_W{1'b1}} : p[PERIOD_W-1:0];
    endfunction

    function automatic logic [TICK_W-1:0] tick_inc(input logic [TICK_W-1:0] t);
        tick_inc = (t < TICK_MAX) ? t + 1'b1 : TICK_MAX;
    endfunction

endpackage

[design/rprm_if.sv]
interface rprm_in_if;
    logic valid;
    logic ready;
    logic marker_low;

    modport source (output valid, output marker_low, input ready);
    modport sink (input valid, input marker_low, output ready);
endinterface

interface rprm_out_if;
    logic              valid;
    logic              ready;
    logic [1:0]        alarm;
    logic              edge_counted;
    logic [15:0]       cycle_period;
    logic [15:0]       measured_period;
    logic signed [15:0] period_delta;

    modport source (output valid, output alarm, output edge_counted, output cycle_period,
                    output measured_period, output period_delta, input ready);
    modport sink (input valid, input alarm, input edge_counted, input cycle_period,
                  input measured_period, input period_delta, output ready);
endinterface

[design/pump_rotation_period_monitor_unit.sv]
// Pump rotation period monitor. Each input item is one tick sample of the rotation
// marker; each item gives exactly one result item. An item is held in the input
// register and then processed into the result register, where it waits until the
// result side takes it; one item is taken every cycle while the result side keeps
// up, since the tick counters and fault count update as each item is processed.
// The user writes configuration (mode, limits, expected period) through cfg_we/
// cfg_index/cfg_data only while no item is in flight; the block does not enforce it.
module pump_rotation_period_monitor_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    rprm_in_if.sink                         in_ch,
    rprm_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [rprm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rprm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rprm_pkg::*;

    cfg_t    cfg;
    result_t result;
    result_t out_data_reg;
    logic    stage_valid_reg;
    logic    stage_marker_reg;
    logic    out_valid_reg;
    logic    advance;

    // move the staged item into the result register when that slot frees up
    assign advance     = stage_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !stage_valid_reg || advance;

    rprm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rprm_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .fire       (advance),
        .marker_low (stage_marker_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                stage_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            stage_marker_reg <= in_ch.marker_low;
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.alarm           = out_data_reg.alarm;
    assign out_ch.edge_counted    = out_data_reg.edge_counted;
    assign out_ch.cycle_period    = out_data_reg.cycle_period;
    assign out_ch.measured_period = out_data_reg.measured_period;
    assign out_ch.period_delta    = out_data_reg.period_delta;

endmodule

[design/rprm_cfg.sv]
module rprm_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rprm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rprm_pkg::CFG_DATA_W-1:0] cfg_data,
    output rprm_pkg::cfg_t                  cfg
);
    import rprm_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:     cfg_reg.mode            <= cfg_data[MODE_W-1:0];
                REG_LOWER:    cfg_reg.lower_limit     <= cfg_data;
                REG_UPPER:    cfg_reg.upper_limit     <= cfg_data;
                REG_EXPECTED: cfg_reg.expected_period <= cfg_data;
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[design/rprm_core.sv]
module rprm_core (
    input  logic              clk,
    input  logic              rst_n,
    input  rprm_pkg::cfg_t    cfg,
    input  logic              fire,
    input  logic              marker_low,
    output rprm_pkg::result_t result
);
    import rprm_pkg::*;

    logic                armed_reg, armed_next;
    logic                prev_high_reg, prev_high_next;
    logic [TICK_W-1:0]   edge_ticks_reg, edge_ticks_next;
    logic [TICK_W-1:0]   total_ticks_reg, total_ticks_next;
    logic [PERIOD_W-1:0] edge_period_reg, edge_period_next;
    logic [PERIOD_W-1:0] cycle_period_reg, cycle_period_next;
    logic [FAULT_W-1:0]  fault_reg, fault_next;

    logic                active;
    logic                falling;
    logic [TICK_W-1:0]   edge_inc;
    logic [TICK_W-1:0]   total_inc;
    logic [PERIOD_W-1:0] cyc_p;
    logic [PERIOD_W-1:0] lower_bound;
    logic [PERIOD_W:0]   upper_bound;
    logic [FAULT_W-1:0]  fault_inc;
    logic [ALARM_W-1:0]  alarm;
    logic                counted;

    assign active      = (cfg.mode != MODE_IDLE);
    assign falling     = marker_low && prev_high_reg;
    assign edge_inc    = tick_inc(edge_ticks_reg);
    assign total_inc   = tick_inc(total_ticks_reg);
    assign cyc_p       = to_period(total_inc);
    assign fault_inc   = (fault_reg < FAULT_MAX) ? fault_reg + 1'b1 : FAULT_MAX;
    assign upper_bound = {1'b0, cfg.upper_limit} + LIMIT_MARGIN;
    // floor the lower bound at zero
    assign lower_bound = ({1'b0, cfg.lower_limit} > LIMIT_MARGIN) ?
                         cfg.lower_limit - LIMIT_MARGIN[PERIOD_W-1:0] : '0;

    always_comb
    begin
        armed_next        = armed_reg;
        prev_high_next    = prev_high_reg;
        edge_ticks_next   = edge_ticks_reg;
        total_ticks_next  = total_ticks_reg;
        edge_period_next  = edge_period_reg;
        cycle_period_next = cycle_period_reg;
        fault_next        = fault_reg;
        alarm             = ALARM_NONE;
        counted           = 1'b0;

        if (active)
        begin
            edge_ticks_next  = edge_inc;
            total_ticks_next = total_inc;
            prev_high_next   = !marker_low;
            if (falling && !armed_reg)
            begin
                armed_next      = 1'b1;
                edge_ticks_next = '0;
            end
            else if (falling)
            begin
                counted           = 1'b1;
                edge_period_next  = to_period(edge_inc);
                cycle_period_next = cyc_p;
                edge_ticks_next   = '0;
                total_ticks_next  = '0;
                if (cfg.mode == MODE_RUN)
                begin
                    if (cyc_p < SHORT_PERIOD)
                    begin
                        fault_next = fault_inc;
                        if (fault_inc > SHORT_LIMIT)
                        begin
                            fault_next = '0;
                            alarm      = ALARM_OVERRUN;
                        end
                    end
                    else if ({1'b0, cyc_p} > upper_bound)
                    begin
                        fault_next = fault_inc;
                        if (fault_inc > RANGE_LIMIT)
                        begin
                            fault_next = '0;
                            alarm      = ALARM_OVERRUN;
                        end
                    end
                    else if (cyc_p < lower_bound)
                    begin
                        fault_next = fault_inc;
                        if (fault_inc > RANGE_LIMIT)
                        begin
                            fault_next = '0;
                            alarm      = ALARM_UNDERRUN;
                        end
                    end
                    else
                    begin
                        fault_next = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg        <= 1'b0;
            prev_high_reg    <= 1'b1;
            edge_ticks_reg   <= '0;
            total_ticks_reg  <= '0;
            edge_period_reg  <= '0;
            cycle_period_reg <= '0;
            fault_reg        <= '0;
        end
        else if (fire)
        begin
            armed_reg        <= armed_next;
            prev_high_reg    <= prev_high_next;
            edge_ticks_reg   <= edge_ticks_next;
            total_ticks_reg  <= total_ticks_next;
            edge_period_reg  <= edge_period_next;
            cycle_period_reg <= cycle_period_next;
            fault_reg        <= fault_next;
        end
    end

    assign result.alarm           = alarm;
    assign result.edge_counted    = counted;
    assign result.cycle_period    = cycle_period_next;
    assign result.measured_period = edge_period_next;
    assign result.period_delta    = edge_period_next - cfg.expected_period;

endmodule
